// ===== design/sft_pkg.sv =====
// Shared types and codes for the source fence table.
// Holds the entry layout, the item and result words and the refusal codes; no dependencies.
`default_nettype none

package sft_pkg;

  typedef enum logic [2:0] {
    REF_NONE        = 3'd0,
    REF_STALE_EPOCH = 3'd1,
    REF_STALE_INC   = 3'd2,
    REF_STALE_SEQ   = 3'd3,
    REF_CONFLICT    = 3'd4,
    REF_FULL        = 3'd5
  } refusal_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  localparam logic ACT_GREETING = 1'b0;
  localparam logic ACT_SNAPSHOT = 1'b1;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] epoch;
    logic [31:0] incarnation;
    logic        mark_set;
    logic [63:0] sequence_mark;
    logic [63:0] digest;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic        action;
    logic [63:0] source_key;
    logic [31:0] epoch_in;
    logic [31:0] incarnation_in;
    logic [63:0] sequence_in;
    logic [63:0] digest_in;
  } item_t;

  typedef struct packed {
    logic     accepted;
    refusal_t refusal;
    logic     marks_cleared;
    logic [3:0] slot_used;
  } result_t;

  typedef struct packed {
    logic wr_en;
    logic alloc;
  } wr_ctl_t;

endpackage

`default_nettype wire

// ===== design/sft_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; no dependencies.
`default_nettype none

module sft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/sft_decide.sv =====
// Fence decision for one item against the entry found by the table scan.
// Produces the write-back entry, its write control and the result word; uses sft_pkg.
`default_nettype none

module sft_decide (
  input  wire  sft_pkg::item_t   item,
  input  wire  sft_pkg::entry_t  entry,
  input  wire logic              found,
  input  wire logic              have_free,
  input  wire logic [3:0]        slot_hit,
  input  wire logic [3:0]        slot_free,
  output sft_pkg::wr_ctl_t       ctl,
  output sft_pkg::entry_t        wr_entry,
  output sft_pkg::result_t       res
);
  import sft_pkg::*;

  logic ep_lt;
  logic ep_eq;
  logic inc_lt;
  logic inc_eq;
  logic inc_gt;
  logic seq_lt;
  logic seq_eq;
  logic seq_gt;
  logic dig_eq;

  assign ep_lt  = item.epoch_in < entry.epoch;
  assign ep_eq  = item.epoch_in == entry.epoch;
  assign inc_lt = item.incarnation_in < entry.incarnation;
  assign inc_eq = item.incarnation_in == entry.incarnation;
  assign inc_gt = item.incarnation_in > entry.incarnation;
  assign seq_lt = item.sequence_in < entry.sequence_mark;
  assign seq_eq = item.sequence_in == entry.sequence_mark;
  assign seq_gt = item.sequence_in > entry.sequence_mark;
  assign dig_eq = item.digest_in == entry.digest;

  always_comb begin
    ctl           = '0;
    wr_entry      = entry;
    res.accepted      = 1'b1;
    res.refusal       = REF_NONE;
    res.marks_cleared = 1'b0;
    res.slot_used     = slot_hit;

    if (!found) begin
      if (!have_free) begin
        res.accepted  = 1'b0;
        res.refusal   = REF_FULL;
        res.slot_used = 4'd0;
      end else begin
        ctl.wr_en              = 1'b1;
        ctl.alloc              = 1'b1;
        res.slot_used          = slot_free;
        wr_entry.key           = item.source_key;
        wr_entry.epoch         = item.epoch_in;
        wr_entry.incarnation   = item.incarnation_in;
        wr_entry.mark_set      = item.action;
        wr_entry.sequence_mark = item.sequence_in;
        wr_entry.digest        = item.digest_in;
      end
    end else if (item.action == ACT_GREETING) begin
      if (ep_lt) begin
        res.accepted = 1'b0;
        res.refusal  = REF_STALE_EPOCH;
      end else if (inc_lt) begin
        res.accepted = 1'b0;
        res.refusal  = REF_STALE_INC;
      end else begin
        ctl.wr_en            = 1'b1;
        wr_entry.epoch       = item.epoch_in;
        wr_entry.incarnation = item.incarnation_in;
        if (inc_gt) begin
          res.marks_cleared      = 1'b1;
          wr_entry.mark_set      = 1'b0;
          wr_entry.sequence_mark = '0;
          wr_entry.digest        = '0;
        end
      end
    end else if (!ep_eq || !inc_eq) begin
      if (ep_lt) begin
        res.accepted = 1'b0;
        res.refusal  = REF_STALE_EPOCH;
      end else if (ep_eq && inc_lt) begin
        res.accepted = 1'b0;
        res.refusal  = REF_STALE_INC;
      end else begin
        ctl.wr_en              = 1'b1;
        wr_entry.epoch         = item.epoch_in;
        wr_entry.incarnation   = item.incarnation_in;
        wr_entry.mark_set      = 1'b1;
        wr_entry.sequence_mark = item.sequence_in;
        wr_entry.digest        = item.digest_in;
      end
    end else if (!entry.mark_set) begin
      ctl.wr_en              = 1'b1;
      wr_entry.mark_set      = 1'b1;
      wr_entry.sequence_mark = item.sequence_in;
      wr_entry.digest        = item.digest_in;
    end else if (seq_lt) begin
      res.accepted = 1'b0;
      res.refusal  = REF_STALE_SEQ;
    end else if (seq_eq && !dig_eq) begin
      res.accepted = 1'b0;
      res.refusal  = REF_CONFLICT;
    end else if (seq_gt) begin
      ctl.wr_en              = 1'b1;
      wr_entry.sequence_mark = item.sequence_in;
      wr_entry.digest        = item.digest_in;
    end
  end

endmodule

`default_nettype wire

// ===== design/source_fence_table.sv =====
// Top level of the source fence table: handshakes, table scan and write-back.
// Uses sft_pkg, sft_ram for the entry store and sft_decide for the fence decision.
//
// Each word is answered by one result word. An item is taken in the idle state, then the
// entry RAM is read one slot per cycle from slot 0 until the source's key matches or
// all TABLE_ENTRIES slots are read, then the decide state decides and writes the entry
// back. An item is done soonest on a hit in slot 0 and latest for an unknown source,
// as the entry RAM has a single read port. The result sits in an output register, so
// a new word is taken while the previous result waits; the decide step holds only while
// that register is still occupied. Slot occupancy is kept in flip-flops cleared by
// reset, so no clearing pass is needed.
`default_nettype none

module source_fence_table #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [63:0] source_key, [95:64] epoch_in, [127:96] incarnation_in,
  // [191:128] sequence_in, [255:192] digest_in
  input  wire logic [255:0] in_tdata,
  // [0] action
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [0] accepted, [3:1] refusal, [4] marks_cleared, [8:5] slot_used, [15:9] zero
  output logic [15:0]       out_tdata
);
  import sft_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  state_t              state_r;
  item_t               item_r;
  logic [CW-1:0]       scan_cnt_r;
  logic                pend_r;
  logic [IW-1:0]       rd_idx_r;
  logic                found_r;
  logic [IW-1:0]       hit_r;
  logic                have_free_r;
  logic [IW-1:0]       free_r;
  entry_t              entry_r;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic                out_tvalid_r;
  result_t             out_res_r;

  logic                issue;
  logic [IW-1:0]       rd_addr;
  logic [ENTRY_W-1:0]  rd_data;
  entry_t              rd_entry;
  logic                hit_now;
  logic                free_now;
  logic                can_load;
  logic                load;
  wr_ctl_t             ctl;
  entry_t              wr_entry;
  result_t             res;
  logic [IW-1:0]       wr_addr;

  assign in_tready  = rst_n && (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_res_r.slot_used, out_res_r.marks_cleared,
                       out_res_r.refusal, out_res_r.accepted};

  assign issue    = (state_r == S_SCAN) && (scan_cnt_r != CW'(TABLE_ENTRIES));
  assign rd_addr  = scan_cnt_r[IW-1:0];
  assign rd_entry = entry_t'(rd_data);
  assign hit_now  = pend_r && valid_r[rd_idx_r] && (rd_entry.key == item_r.source_key);
  assign free_now = pend_r && !valid_r[rd_idx_r] && !have_free_r;
  assign can_load = !out_tvalid_r || out_tready;
  assign load     = (state_r == S_DECIDE) && can_load;
  assign wr_addr  = ctl.alloc ? free_r : hit_r;

  sft_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (load && ctl.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sft_decide u_decide (
    .item      (item_r),
    .entry     (entry_r),
    .found     (found_r),
    .have_free (have_free_r),
    .slot_hit  (4'(hit_r)),
    .slot_free (4'(free_r)),
    .ctl       (ctl),
    .wr_entry  (wr_entry),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_r       <= 1'b0;
      found_r      <= 1'b0;
      have_free_r  <= 1'b0;
      valid_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r     <= S_SCAN;
            pend_r      <= 1'b0;
            found_r     <= 1'b0;
            have_free_r <= 1'b0;
          end
        end
        S_SCAN: begin
          if (free_now) begin
            have_free_r <= 1'b1;
          end
          if (hit_now) begin
            found_r <= 1'b1;
            pend_r  <= 1'b0;
            state_r <= S_DECIDE;
          end else begin
            pend_r <= issue;
            if (scan_cnt_r == CW'(TABLE_ENTRIES)) begin
              state_r <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          if (load) begin
            state_r <= S_IDLE;
            if (ctl.alloc) begin
              valid_r[free_r] <= 1'b1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      item_r.action         <= in_tuser;
      item_r.source_key     <= in_tdata[63:0];
      item_r.epoch_in       <= in_tdata[95:64];
      item_r.incarnation_in <= in_tdata[127:96];
      item_r.sequence_in    <= in_tdata[191:128];
      item_r.digest_in      <= in_tdata[255:192];
      scan_cnt_r            <= '0;
    end
    if (issue) begin
      rd_idx_r   <= rd_addr;
      scan_cnt_r <= scan_cnt_r + CW'(1);
    end
    if (free_now) begin
      free_r <= rd_idx_r;
    end
    if (hit_now) begin
      hit_r   <= rd_idx_r;
      entry_r <= rd_entry;
    end
    if (load) begin
      out_res_r <= res;
    end
  end

endmodule

`default_nettype wire
